[hw/rtl/seeded_prng_range_draw_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the seeded PRNG range draw core
// Shorthand for clocked implications sampled on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SEEDED_PRNG_RANGE_DRAW_CORE_ASSERT_SVH
`define SEEDED_PRNG_RANGE_DRAW_CORE_ASSERT_SVH

// Same-cycle implication
`define SPRD_ASSERT_IMPL(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SPRD_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sprd_pkg.sv]
// ----------------------------------------------------------------------------
// sprd_pkg
// Shared constants and controller/datapath interface types for the
// seeded PRNG range draw core.
// ----------------------------------------------------------------------------
`default_nettype none

package sprd_pkg;

  // splitmix64 constants
  localparam logic [63:0] SM_GAMMA = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] SM_MUL1  = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] SM_MUL2  = 64'h94d0_49bb_1331_11eb;

  // Partial-product passes of a 64x64 (low half) multiply on a 32x32 unit
  typedef enum logic [1:0] {
    MUL_LO_LO = 2'd0,
    MUL_LO_HI = 2'd1,
    MUL_HI_LO = 2'd2
  } sprd_mul_phase_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic            latch;     // capture request bounds, load seed copy
    logic            sm_add;    // splitmix accumulator += gamma
    logic            xs30;      // z ^= z >> 30
    logic            xs27;      // z ^= z >> 27
    logic            mul_en;    // one multiply pass
    sprd_mul_phase_t mul_phase;
    logic            mul_sel;   // 0: SM_MUL1, 1: SM_MUL2
    logic            store;     // write finished splitmix word
    logic [1:0]      word_idx;
    logic            step;      // xoshiro256** advance
    logic            keep_lo;   // result = range_low
    logic            div;       // one remainder bit
    logic            add_lo;    // result = range_low + remainder
    logic            out_load;  // result -> output register
  } sprd_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic span_one;   // bounds equal
    logic span_zero;  // full 64-bit span
  } sprd_status_t;

endpackage

`default_nettype wire

[hw/rtl/sprd_datapath.sv]
// ----------------------------------------------------------------------------
// sprd_datapath
// Generator state, splitmix64 seeding unit with a shared 32x32 multiplier,
// bit-serial remainder unit and result/output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sprd_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sprd_pkg::sprd_cmd_t  cmd,
  input  wire logic [63:0]          seed,
  input  wire logic [63:0]          range_low,
  input  wire logic [63:0]          range_high,
  output sprd_pkg::sprd_status_t    status,
  output logic [63:0]               draw_value
);

  import sprd_pkg::*;

  logic [3:0][63:0] gen_r;
  logic [63:0]      acc_r;
  logic [63:0]      z_r;
  logic [63:0]      prod_r;
  logic [63:0]      lo_r;
  logic [63:0]      span_r;
  logic [63:0]      raw_r;
  logic [63:0]      rem_r;
  logic [63:0]      res_r;
  logic [63:0]      out_r;

  logic [63:0]      acc_nxt;
  logic [63:0]      sm_word;
  logic [63:0]      mul_const;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      mul_p;
  logic [63:0]      prod_nxt;

  logic [63:0]      s1x5;
  logic [63:0]      s1rot;
  logic [63:0]      draw_raw;
  logic [63:0]      step_t;
  logic [63:0]      n0, n1, n2, n3;
  logic [3:0][63:0] gen_nxt;

  logic [64:0]      rem_sh;
  logic [64:0]      rem_diff;
  logic [63:0]      rem_nxt;

  // splitmix pieces
  assign acc_nxt = acc_r + SM_GAMMA;
  assign sm_word = z_r ^ (z_r >> 31);

  // Shared multiplier: operand halves picked by pass
  assign mul_const = cmd.mul_sel ? SM_MUL2 : SM_MUL1;

  always_comb begin
    mul_a = z_r[31:0];
    mul_b = mul_const[31:0];
    case (cmd.mul_phase)
      MUL_LO_LO: begin
        mul_a = z_r[31:0];
        mul_b = mul_const[31:0];
      end
      MUL_LO_HI: begin
        mul_a = z_r[31:0];
        mul_b = mul_const[63:32];
      end
      MUL_HI_LO: begin
        mul_a = z_r[63:32];
        mul_b = mul_const[31:0];
      end
      default: begin
        mul_a = z_r[31:0];
        mul_b = mul_const[31:0];
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Cross terms only contribute their low half at bit 32
  always_comb begin
    if (cmd.mul_phase == MUL_LO_LO) begin
      prod_nxt = mul_p;
    end else begin
      prod_nxt = prod_r + {mul_p[31:0], 32'd0};
    end
  end

  // xoshiro256** output and state update
  assign s1x5     = gen_r[1] + {gen_r[1][61:0], 2'b00};
  assign s1rot    = {s1x5[56:0], s1x5[63:57]};
  assign draw_raw = s1rot + {s1rot[60:0], 3'b000};
  assign step_t   = {gen_r[1][46:0], 17'd0};
  assign n2       = gen_r[2] ^ gen_r[0];
  assign n3       = gen_r[3] ^ gen_r[1];
  assign n1       = gen_r[1] ^ n2;
  assign n0       = gen_r[0] ^ n3;
  assign gen_nxt[0] = n0;
  assign gen_nxt[1] = n1;
  assign gen_nxt[2] = n2 ^ step_t;
  assign gen_nxt[3] = {n3[18:0], n3[63:19]};

  // Restoring remainder, one dividend bit per cycle
  assign rem_sh   = {rem_r, raw_r[63]};
  assign rem_diff = rem_sh - {1'b0, span_r};
  assign rem_nxt  = rem_diff[64] ? rem_sh[63:0] : rem_diff[63:0];

  // Generator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= '0;
    end else if (cmd.store) begin
      gen_r[cmd.word_idx] <= sm_word;
    end else if (cmd.step) begin
      gen_r <= gen_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lo_r   <= range_low;
      span_r <= range_high - range_low + 64'd1;
      acc_r  <= seed;
      res_r  <= '0;
    end
    if (cmd.sm_add) begin
      acc_r <= acc_nxt;
      z_r   <= acc_nxt;
    end
    if (cmd.xs30) begin
      z_r <= z_r ^ (z_r >> 30);
    end
    if (cmd.xs27) begin
      z_r <= z_r ^ (z_r >> 27);
    end
    if (cmd.mul_en) begin
      if (cmd.mul_phase == MUL_HI_LO) begin
        z_r <= prod_nxt;
      end else begin
        prod_r <= prod_nxt;
      end
    end
    if (cmd.step) begin
      raw_r <= draw_raw;
      res_r <= draw_raw;
      rem_r <= '0;
    end
    if (cmd.div) begin
      rem_r <= rem_nxt;
      raw_r <= {raw_r[62:0], 1'b0};
    end
    if (cmd.keep_lo) begin
      res_r <= lo_r;
    end
    if (cmd.add_lo) begin
      res_r <= lo_r + rem_r;
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign status.span_one  = (span_r == 64'd1);
  assign status.span_zero = (span_r == 64'd0);
  assign draw_value       = out_r;

endmodule

`default_nettype wire

[hw/rtl/sprd_ctrl.sv]
// ----------------------------------------------------------------------------
// sprd_ctrl
// Request sequencer: decodes the request, steps the datapath through
// seeding, generator advance and remainder loop, and owns the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module sprd_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic [1:0]             in_req_type,
  output logic                        in_stall,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  input  wire sprd_pkg::sprd_status_t status,
  output sprd_pkg::sprd_cmd_t         cmd
);

  import sprd_pkg::*;

  // Request codes
  localparam logic [1:0] REQ_RESEED = 2'd0;
  localparam logic [1:0] REQ_RAW    = 2'd1;
  localparam logic [1:0] REQ_RANGE  = 2'd2;

  localparam logic [5:0] DIV_LAST  = 6'd63;
  localparam logic [1:0] WORD_LAST = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_STEP,
    ST_DIV,
    ST_ADD_LO,
    ST_SM_ADD,
    ST_SM_XS30,
    ST_SM_MUL1,
    ST_SM_XS27,
    ST_SM_MUL2,
    ST_SM_STORE,
    ST_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [1:0] widx_r, widx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    cnt_nxt       = cnt_r;
    widx_nxt      = widx_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.word_idx  = widx_r;
    cmd.mul_phase = sprd_mul_phase_t'(cnt_r[1:0]);

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          cmd.latch = 1'b1;
          kind_nxt  = in_req_type;
          widx_nxt  = '0;
          case (in_req_type)
            REQ_RESEED: state_nxt = ST_SM_ADD;
            REQ_RAW:    state_nxt = ST_STEP;
            REQ_RANGE:  state_nxt = ST_CHECK;
            default:    state_nxt = ST_FIN;
          endcase
        end
      end
      // Equal bounds return range_low without touching the generator
      ST_CHECK: begin
        if (status.span_one) begin
          cmd.keep_lo = 1'b1;
          state_nxt   = ST_FIN;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        cnt_nxt  = '0;
        if (kind_r == REQ_RANGE && !status.span_zero) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_ADD_LO;
        end
      end
      ST_ADD_LO: begin
        cmd.add_lo = 1'b1;
        state_nxt  = ST_FIN;
      end
      // splitmix64 round, once per state word
      ST_SM_ADD: begin
        cmd.sm_add = 1'b1;
        state_nxt  = ST_SM_XS30;
      end
      ST_SM_XS30: begin
        cmd.xs30  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_SM_MUL1;
      end
      ST_SM_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 1'b0;
        cnt_nxt     = cnt_r + 6'd1;
        if (cmd.mul_phase == MUL_HI_LO) begin
          state_nxt = ST_SM_XS27;
        end
      end
      ST_SM_XS27: begin
        cmd.xs27  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_SM_MUL2;
      end
      ST_SM_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 1'b1;
        cnt_nxt     = cnt_r + 6'd1;
        if (cmd.mul_phase == MUL_HI_LO) begin
          state_nxt = ST_SM_STORE;
        end
      end
      ST_SM_STORE: begin
        cmd.store = 1'b1;
        widx_nxt  = widx_r + 2'd1;
        if (widx_r == WORD_LAST) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_SM_ADD;
        end
      end
      // Hand the result over once the output register is free
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= REQ_RESEED;
      cnt_r       <= '0;
      widx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      cnt_r       <= cnt_nxt;
      widx_r      <= widx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/seeded_prng_range_draw_core.sv]
// ----------------------------------------------------------------------------
// seeded_prng_range_draw_core
// xoshiro256** generator with splitmix64 seeding and ranged draws.
// ----------------------------------------------------------------------------
// One request is in work at a time; the result sits in an output register so
// the next request is taken while it waits. Request kinds: raw draw, ranged
// draw with equal bounds, ranged draw over the full 64-bit span, any other
// ranged draw (run through the remainder unit, which retires one dividend bit
// per cycle), reseed (four splitmix64 rounds, each with two 64-bit products
// built from three passes through one 32x32 multiplier) and an unused request
// code, which goes straight to the result handover. The seed register sits at
// byte address 0 of the APB port.
`default_nettype none

module seeded_prng_range_draw_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [63:0] in_range_low,
  input  wire logic [63:0] in_range_high,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_draw_value,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  import sprd_pkg::*;

  localparam logic [2:0] ADDR_SEED = 3'd0;

  logic [63:0]  seed_r;
  sprd_cmd_t    cmd;
  sprd_status_t status;

  // Seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (psel && penable && pwrite && paddr == ADDR_SEED) begin
      seed_r <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SEED) ? seed_r : 64'd0;

  sprd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .cmd         (cmd)
  );

  sprd_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .seed       (seed_r),
    .range_low  (in_range_low),
    .range_high (in_range_high),
    .status     (status),
    .draw_value (out_draw_value)
  );

endmodule

`default_nettype wire

[hw/rtl/sprd_checker.sv]
// ----------------------------------------------------------------------------
// sprd_checker
// Port-level checks on the draw core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "seeded_prng_range_draw_core_assert.svh"

module sprd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_draw_value
);

  // Stalled result holds
  `SPRD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(out_draw_value), "stalled result changed")

  // A taken request keeps the core busy
  `SPRD_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall,
                    "core idle right after a request")

  // A result only appears at the end of request work
  `SPRD_ASSERT_IMPL(a_result_from_work, $rose(out_valid), $past(in_stall),
                    "result without request work")

  // Idle core with its result taken shows no new result next cycle
  `SPRD_ASSERT_NEXT(a_no_spurious, out_valid && !out_stall && !in_stall, !out_valid,
                    "spurious result")

endmodule

bind seeded_prng_range_draw_core sprd_checker u_sprd_checker (.*);

`default_nettype wire
